### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/dvl_pkg.sv
package dvl_pkg;

   // Field widths
   localparam int ELAPSED_W  = 16;
   localparam int ROOT_W     = 20;
   localparam int CV_W       = 12;
   localparam int HARM_W     = 23;
   localparam int IDX_W      = 3;
   localparam int DUTY_W     = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEDAL_MODE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIMMER_RATE = 1'b1;

   localparam int PEDAL_W   = 2;
   localparam int SHIMMER_W = 4;
   localparam logic [PEDAL_W-1:0]   PEDAL_SUB        = 2'd0;
   localparam logic [PEDAL_W-1:0]   PEDAL_FIFTH      = 2'd1;
   localparam logic [SHIMMER_W-1:0] SHIMMER_RESET    = 4'd4;
   localparam logic [SHIMMER_W-1:0] SHIMMER_FROZEN   = 4'd0;

   // Shared multiplier
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 20;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // LFO rate constants, split in two 18-bit partial operands
   localparam int RATE_W      = 36;
   localparam int RATE_HALF_W = 18;
   localparam int LO_PROD_W   = MUL_A_W + RATE_HALF_W;
   localparam int BASE_W      = 8;
   localparam logic [BASE_W-1:0] BASE_OFFSET = 8'd5;
   localparam logic [RATE_W-1:0] RATE_Q [3] = '{
      36'd29358905040, 36'd38460165602, 36'd50790905719};

   // Start phases, turns in Q48
   localparam logic [47:0] PHASE_INIT_Q48 [3] = '{
      48'd0, 48'd76156827561877, 48'd152313655123754};

   // Divide by three: multiply by ceil(2^21 / 3), shift right 21
   localparam logic [MUL_B_W-1:0] RECIP3       = 20'd699051;
   localparam int                 RECIP3_SHIFT = 21;

   // Harmonic selection
   localparam logic [14:0] HARM_STEP = 15'd4095;
   localparam logic [3:0]  HARM_MULT [6] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8};

   localparam logic [DUTY_W-1:0] DUTY_REST = 7'd50;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_BASE  = 9'b000000010,
      ST_PEDAL = 9'b000000100,
      ST_HARM  = 9'b000001000,
      ST_HCAP  = 9'b000010000,
      ST_LO    = 9'b000100000,
      ST_HI    = 9'b001000000,
      ST_ACC   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

endpackage

### rtl/dvl_mul.sv
module dvl_mul
   import dvl_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] mul_a,
   input  logic [MUL_B_W-1:0] mul_b,
   output logic [MUL_P_W-1:0] prod_ff
);

   logic [MUL_P_W-1:0] prod_in;

   // Form the product, register it for the next step
   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### rtl/drone_voice_lfo_pwm.sv
// Channel  Dir  Handshake                Payload
// req      in   req_tvalid/req_tready    elapsed_us, root_hz, mod_cv
// rsp      out  rsp_tvalid/rsp_tready    three frequencies, harmonic index, three duties
// csr      in   csr_we                   pedal_mode (index 0), shimmer_rate (index 1)
//
// A new word is accepted only once the sequencer is back in idle; the LFO steps are skipped
// when shimmer_rate is zero. Otherwise the single 24x20 multiplier is used in nine steps, two
// partial products per LFO voice.
// Synchronous reset sets the sequencer, output valid, settings and the LFO start phases.
// A finished word waits in the output register; the sequencer holds before writing the
// next one until the earlier word is taken.
module drone_voice_lfo_pwm
   import dvl_pkg::*;
#(
   parameter int PHASE_BITS       = 32,
   parameter int SINE_TABLE_DEPTH = 256
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] elapsed_us, [35:16] root_hz, [47:36] mod_cv
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [19:0] fundamental_hz, [39:20] pedal_hz, [62:40] harmonic_hz, [65:63] harmonic_index,
   // [72:66] duty_fundamental, [79:73] duty_pedal, [86:80] duty_harmonic, [87] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Table index bits; SINE_TABLE_DEPTH must be a power of two, which the block does not check
   localparam int TI_BITS = $clog2(SINE_TABLE_DEPTH);
   localparam int ROM_W   = SINE_TABLE_DEPTH * DUTY_W;
   localparam logic [63:0] DEPTH64    = 64'(SINE_TABLE_DEPTH);
   localparam logic [63:0] Q30_ONE    = 64'd1073741824;
   localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

   // Magnitude of sin(pi/2 * r / depth) in Q30
   function automatic logic [63:0] sine_quarter(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] res;
      if (r == 64'd0) begin
         res = 64'd0;
      end else if (r >= DEPTH64) begin
         res = Q30_ONE;
      end else if (64'd3 * r == DEPTH64) begin
         res = Q30_ONE >> 1;
      end else begin
         x  = (HALFPI_Q30 * r) / DEPTH64;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         res = (x * t) >> 30;
      end
      return res;
   endfunction

   // Duty table, floor(38 + 26 sin), built at elaboration
   function automatic logic [ROM_W-1:0] build_duty_rom();
      logic [ROM_W-1:0] rom;
      logic [63:0]      n;
      logic [63:0]      q;
      logic [63:0]      r;
      logic [63:0]      m;
      logic [63:0]      d;
      int               i;
      rom = '0;
      for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
         n = 64'd4 * 64'(i);
         q = n / DEPTH64;
         r = n % DEPTH64;
         if (q[0]) begin
            r = DEPTH64 - r;
         end
         m = sine_quarter(r);
         if (q >= 64'd2) begin
            d = 64'd38 - ((64'd26 * m + Q30_ONE - 64'd1) >> 30);
         end else begin
            d = 64'd38 + ((64'd26 * m) >> 30);
         end
         rom[i*DUTY_W +: DUTY_W] = d[DUTY_W-1:0];
      end
      return rom;
   endfunction

   localparam logic [ROM_W-1:0] DUTY_ROM = build_duty_rom();

   state_type               state_ff, state_in;
   logic [ELAPSED_W-1:0]    dt_ff, dt_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [CV_W-1:0]         cv_ff, cv_in;
   logic [1:0]              voice_ff, voice_in;
   logic [MUL_A_W-1:0]      a_ff, a_in;
   logic [LO_PROD_W-1:0]    lo_ff, lo_in;
   logic [ROOT_W-1:0]       pedal_ff, pedal_in;
   logic [HARM_W-1:0]       harm_ff, harm_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [PHASE_BITS-1:0]   phase_ff [3];
   logic [PHASE_BITS-1:0]   phase_in [3];
   logic [PEDAL_W-1:0]      pedal_mode_ff, pedal_mode_in;
   logic [SHIMMER_W-1:0]    shimmer_ff, shimmer_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [MUL_A_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]      mul_b;
   logic [MUL_P_W-1:0]      prod_ff;
   logic [BASE_W-1:0]       base;
   logic [14:0]             cv6;
   logic [IDX_W-1:0]        idx_sel;
   logic [63:0]             inc_sum;
   logic [TI_BITS-1:0]      ti [3];
   logic [DUTY_W-1:0]       duty [3];

   dvl_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // LFO speed step: 5 + 12 * shimmer
   assign base = BASE_OFFSET + {1'b0, shimmer_ff, 3'b000} + {2'b00, shimmer_ff, 2'b00};

   // Harmonic index: count thresholds cv*6 crosses, saturating at five
   assign cv6 = {1'b0, cv_ff, 2'b00} + {2'b00, cv_ff, 1'b0};
   assign idx_sel = IDX_W'(cv6 >= HARM_STEP) + IDX_W'(cv6 >= 15'(2 * 4095))
                  + IDX_W'(cv6 >= 15'(3 * 4095)) + IDX_W'(cv6 >= 15'(4 * 4095))
                  + IDX_W'(cv6 >= 15'(5 * 4095));

   // Phase increment: rejoin the two partial products
   assign inc_sum = 64'({prod_ff[LO_PROD_W-1:0], {RATE_HALF_W{1'b0}}}) + 64'(lo_ff);

   // Look up the three duties from the current phases, or give the rest duty when frozen
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         ti[v] = phase_ff[v][PHASE_BITS-1 -: TI_BITS];
         if (shimmer_ff == SHIMMER_FROZEN) begin
            duty[v] = DUTY_REST;
         end else begin
            duty[v] = DUTY_ROM[ti[v]*DUTY_W +: DUTY_W];
         end
      end
   end

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_BASE: begin
            mul_a = MUL_A_W'(dt_ff);
            mul_b = MUL_B_W'(base);
         end
         ST_PEDAL: begin
            mul_a = MUL_A_W'({root_ff, 1'b0});
            mul_b = RECIP3;
         end
         ST_HARM: begin
            mul_a = MUL_A_W'(root_ff);
            mul_b = MUL_B_W'(HARM_MULT[idx_sel]);
         end
         ST_LO: begin
            mul_a = a_ff;
            mul_b = MUL_B_W'(RATE_Q[voice_ff][RATE_HALF_W-1:0]);
         end
         ST_HI: begin
            mul_a = a_ff;
            mul_b = MUL_B_W'(RATE_Q[voice_ff][RATE_W-1:RATE_HALF_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer and register next values
   always_comb begin
      state_in      = state_ff;
      dt_in         = dt_ff;
      root_in       = root_ff;
      cv_in         = cv_ff;
      voice_in      = voice_ff;
      a_in          = a_ff;
      lo_in         = lo_ff;
      pedal_in      = pedal_ff;
      harm_in       = harm_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      pedal_mode_in = pedal_mode_ff;
      shimmer_in    = shimmer_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_PEDAL_MODE:   pedal_mode_in = csr_wdata[PEDAL_W-1:0];
            CSR_SHIMMER_RATE: shimmer_in    = csr_wdata[SHIMMER_W-1:0];
            default:          pedal_mode_in = pedal_mode_ff;
         endcase
      end

      // Drop the output word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dt_in    = req_tdata[15:0];
               root_in  = req_tdata[35:16];
               cv_in    = req_tdata[47:36];
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            state_in = ST_PEDAL;
         end
         ST_PEDAL: begin
            a_in     = prod_ff[MUL_A_W-1:0];
            state_in = ST_HARM;
         end
         ST_HARM: begin
            if (pedal_mode_ff == PEDAL_SUB) begin
               pedal_in = root_ff >> 1;
            end else if (pedal_mode_ff == PEDAL_FIFTH) begin
               pedal_in = prod_ff[RECIP3_SHIFT +: ROOT_W];
            end else begin
               pedal_in = root_ff;
            end
            idx_in   = idx_sel;
            state_in = ST_HCAP;
         end
         ST_HCAP: begin
            harm_in  = prod_ff[HARM_W-1:0];
            voice_in = 2'd0;
            if (shimmer_ff == SHIMMER_FROZEN) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            state_in = ST_HI;
         end
         ST_HI: begin
            lo_in    = prod_ff[LO_PROD_W-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Advance this voice's phase, wrap once per turn
            phase_in[voice_ff] = phase_ff[voice_ff] + inc_sum[63 -: PHASE_BITS];
            voice_in = voice_ff + 2'd1;
            if (voice_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_LO;
            end
         end
         ST_OUT: begin
            // Hold until the earlier word has left the output register
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, duty[2], duty[1], duty[0], idx_ff,
                               harm_ff, pedal_ff, root_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         voice_ff      <= 2'd0;
         rsp_valid_ff  <= 1'b0;
         pedal_mode_ff <= PEDAL_SUB;
         shimmer_ff    <= SHIMMER_RESET;
         for (int v = 0; v < 3; v++) begin
            phase_ff[v] <= PHASE_INIT_Q48[v][47 -: PHASE_BITS];
         end
      end else begin
         state_ff      <= state_in;
         voice_ff      <= voice_in;
         rsp_valid_ff  <= rsp_valid_in;
         pedal_mode_ff <= pedal_mode_in;
         shimmer_ff    <= shimmer_in;
         phase_ff      <= phase_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      root_ff     <= root_in;
      cv_ff       <= cv_in;
      a_ff        <= a_in;
      lo_ff       <= lo_in;
      pedal_ff    <= pedal_in;
      harm_ff     <= harm_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/dvl_checker.sv
`include "assert_macros.svh"

module dvl_checker
   import dvl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // Output word holds while stalled
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp word changed while stalled")

   // The block is busy right after taking a word
   `ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "req taken again without a busy cycle")

   // Harmonic index saturates at five
   `ASSERT_SAME(a_idx_range, clock, reset, rsp_tvalid, rsp_tdata[65:63] <= 3'd5, "harmonic index above five")

   // The fundamental duty stays inside the sine swing
   `ASSERT_SAME(a_duty_range, clock, reset, rsp_tvalid, (rsp_tdata[72:66] <= 7'd64) && (rsp_tdata[72:66] >= 7'd12), "fundamental duty out of range")

endmodule

bind drone_voice_lfo_pwm dvl_checker u_dvl_checker (.*);

### bench/tb_drone_voice_lfo_pwm.sv
module tb_drone_voice_lfo_pwm;
   timeunit 1ns;
   timeprecision 1ps;
   import dvl_pkg::*;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int              LUT_DEPTH   = 256;
   localparam int              PWM_CENTER  = 50;

   // One control tick as it travels on req_tdata
   typedef struct packed {
      logic [CV_W-1:0]      mod_cv;
      logic [ROOT_W-1:0]    root_hz;
      logic [ELAPSED_W-1:0] elapsed_us;
   } tick_type;

   // Voice set predicted for one tick
   typedef struct {
      logic [ROOT_W-1:0] fundamental_hz;
      logic [ROOT_W-1:0] pedal_hz;
      logic [HARM_W-1:0] harmonic_hz;
      logic [IDX_W-1:0]  harmonic_index;
      logic [DUTY_W-1:0] duty [3];
   } voices_type;

   // Voice predictor with its own LFO phases and register copies
   class voice_scoreboard;
      logic [31:0]       lfo_phase [3];
      logic [1:0]        pedal_mode;
      logic [3:0]        shimmer;
      logic [DUTY_W-1:0] duty_lut [LUT_DEPTH];
      longint unsigned   lfo_rate [3];
      longint unsigned   harm_times [6];
      voices_type        expected_voices [$];
      int                errors;

      function new();
         longint unsigned start_q48 [3];
         longint unsigned n, q, r, m;
         lfo_rate   = '{64'd29358905040, 64'd38460165602, 64'd50790905719};
         harm_times = '{64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd8};
         start_q48  = '{64'd0, 64'd76156827561877, 64'd152313655123754};
         for (int i = 0; i < 3; i++) lfo_phase[i] = 32'(start_q48[i] >> 16);
         // fold each entry onto the first quarter wave and round down
         for (int i = 0; i < LUT_DEPTH; i++) begin
            n = 64'(4 * i);
            q = n / LUT_DEPTH;
            r = n % LUT_DEPTH;
            if (q[0]) r = LUT_DEPTH - r;
            m = quarter_sine(r, LUT_DEPTH);
            if (q >= 2) duty_lut[i] = DUTY_W'(38 - ((26 * m + Q30_ONE - 1) >> 30));
            else        duty_lut[i] = DUTY_W'(38 + ((26 * m) >> 30));
         end
         pedal_mode = PEDAL_SUB;
         shimmer    = SHIMMER_RESET;
         errors     = 0;
      endfunction

      // sin(pi/2 * r/d) in Q30; exact at zero, one half and one
      function longint unsigned quarter_sine(longint unsigned r, longint unsigned d);
         longint unsigned x, x2, t, k;
         if (r == 0) return 0;
         if (r >= d) return Q30_ONE;
         if (3 * r == d) return Q30_ONE / 2;
         x  = (HALF_PI_Q30 * r) / d;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         for (k = 15; k >= 3; k -= 2) t = Q30_ONE - ((x2 * t) >> 30) / ((k - 1) * k);
         return (x * t) >> 30;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_PEDAL_MODE) pedal_mode = value[1:0];
         else shimmer = value;
      endfunction

      // Advance the LFOs and queue the voice set for an accepted tick
      function void note_tick(tick_type t);
         voices_type      v;
         longint unsigned root, cv, dt, idx, base, inc;
         root = 64'(t.root_hz);
         cv   = 64'(t.mod_cv);
         dt   = 64'(t.elapsed_us);
         idx  = (cv * 6) / 4095;
         if (idx > 5) idx = 5;
         v.fundamental_hz = t.root_hz;
         case (pedal_mode)
            PEDAL_SUB:   v.pedal_hz = ROOT_W'(root >> 1);
            PEDAL_FIFTH: v.pedal_hz = ROOT_W'((root * 2) / 3);
            default:     v.pedal_hz = ROOT_W'(root);
         endcase
         v.harmonic_hz    = HARM_W'(root * harm_times[idx]);
         v.harmonic_index = IDX_W'(idx);
         if (shimmer != SHIMMER_FROZEN) begin
            base = 64'(shimmer);
            base = 5 + 12 * base;
            for (int k = 0; k < 3; k++) begin
               inc          = (dt * base * lfo_rate[k]) >> 32;
               lfo_phase[k] = lfo_phase[k] + inc[31:0];
               v.duty[k]    = duty_lut[lfo_phase[k][31:24]];
            end
         end else begin
            for (int k = 0; k < 3; k++) v.duty[k] = DUTY_W'(PWM_CENTER);
         end
         expected_voices.push_back(v);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      // Match a response word against the oldest voice set
      function void check_word(logic [RSP_DATA_W-1:0] d);
         voices_type e;
         if (expected_voices.size() == 0) begin
            errors++;
            $display("%0t: response word with nothing expected, expected none actual %h",
                     $time, d);
            return;
         end
         e = expected_voices.pop_front();
         compare_field("fundamental_hz", e.fundamental_hz, d[19:0]);
         compare_field("pedal_hz", e.pedal_hz, d[39:20]);
         compare_field("harmonic_hz", e.harmonic_hz, d[62:40]);
         compare_field("harmonic_index", e.harmonic_index, d[65:63]);
         compare_field("duty_fundamental", e.duty[0], d[72:66]);
         compare_field("duty_pedal", e.duty[1], d[79:73]);
         compare_field("duty_harmonic", e.duty[2], d[86:80]);
      endfunction

      function int pending();
         return expected_voices.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   voice_scoreboard sb;
   int              burst_left = 0;
   int              stall_mode = 0;
   int              stall_left = 0;

   drone_voice_lfo_pwm i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Offer one tick, opening a new burst after a random gap when the last one ran out
   task automatic send_tick(tick_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(t);
      burst_left--;
   endtask

   // Drop valid and let every outstanding word drain
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (16) @(posedge clock);
   endtask

   // Write both registers on back-to-back cycles
   task automatic program_regs(logic [CSR_DATA_W-1:0] pedal, logic [CSR_DATA_W-1:0] rate);
      csr_we    <= 1'b1;
      csr_index <= CSR_PEDAL_MODE;
      csr_wdata <= pedal;
      @(posedge clock);
      sb.write_reg(CSR_PEDAL_MODE, pedal);
      csr_index <= CSR_SHIMMER_RATE;
      csr_wdata <= rate;
      @(posedge clock);
      sb.write_reg(CSR_SHIMMER_RATE, rate);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Bias toward long ticks so the LFOs sweep the whole sine table
   function automatic tick_type random_tick();
      tick_type t;
      case ($urandom_range(0, 7))
         0:       t.elapsed_us = '0;
         1:       t.elapsed_us = ELAPSED_W'($urandom_range(1, 255));
         2, 3:    t.elapsed_us = ELAPSED_W'($urandom);
         default: t.elapsed_us = ELAPSED_W'($urandom_range(49152, 65535));
      endcase
      case ($urandom_range(0, 9))
         0:       t.root_hz = '0;
         1:       t.root_hz = '1;
         default: t.root_hz = ROOT_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       t.mod_cv = '0;
         1:       t.mod_cv = '1;
         2:       t.mod_cv = CV_W'($urandom_range(3400, 4095));
         default: t.mod_cv = CV_W'($urandom);
      endcase
      return t;
   endfunction

   // Check each response word and stall on a pattern of shifting stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 60);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] pedal_plan [10];
      logic [CSR_DATA_W-1:0] rate_plan [10];
      sb = new();
      pedal_plan = '{4'd1, 4'd2, 4'd3, 4'd0, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
      rate_plan  = '{4'd10, 4'd0, 4'd15, 4'd1, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
      for (int p = 5; p < 10; p++) begin
         pedal_plan[p] = CSR_DATA_W'($urandom_range(0, 3));
         rate_plan[p]  = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes and harmonic boundaries at the reset register values
      send_tick('{12'd0, 20'd0, 16'd0});
      send_tick('{12'd4095, 20'hFFFFF, 16'd65535});
      send_tick('{12'd0, 20'd0, 16'd65535});
      send_tick('{12'd4095, 20'hFFFFF, 16'd0});
      send_tick('{12'd1, 20'd1, 16'd1});
      send_tick('{12'd682, 20'h80000, 16'd32768});
      send_tick('{12'd683, 20'd12345, 16'd40000});
      send_tick('{12'd1364, 20'd3, 16'd50000});
      send_tick('{12'd1365, 20'h7FFFF, 16'd60000});
      send_tick('{12'd2047, 20'hAAAAA, 16'd20000});
      send_tick('{12'd2048, 20'h55555, 16'd65535});
      send_tick('{12'd2730, 20'hFFFFE, 16'd30000});
      send_tick('{12'd2731, 20'h5A5A5, 16'd5555});
      send_tick('{12'd3412, 20'h10000, 16'd65535});
      send_tick('{12'd3413, 20'h00100, 16'd12345});
      send_tick('{12'd4094, 20'hFFFFF, 16'd65535});
      finish_phase();

      // Random ticks under a sweep of register settings
      for (int p = 0; p < 10; p++) begin
         program_regs(pedal_plan[p], rate_plan[p]);
         repeat ($urandom_range(35, 65)) send_tick(random_tick());
         finish_phase();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #1000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### drone_voice_lfo_pwm.f
+incdir+rtl
rtl/dvl_pkg.sv
rtl/dvl_mul.sv
rtl/drone_voice_lfo_pwm.sv
rtl/dvl_checker.sv
bench/tb_drone_voice_lfo_pwm.sv
